[design/rwstp_pkg.sv]
// Shared types, constants and character helpers for the score text parser.
`timescale 1ns / 1ps

package rwstp_pkg;

  localparam int unsigned ACCUM_WIDTH_DEF = 32;
  localparam logic [31:0] CHIP_RATE_RESET = 32'd49716;

  // result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DELAY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // characters
  localparam logic [7:0] CH_I      = 8'h69;  // 'i'
  localparam logic [7:0] CH_S      = 8'h73;  // 's'
  localparam logic [7:0] CH_R      = 8'h72;  // 'r'
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;  // 'a' - 10

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  value;
    logic [31:0] ticks;
    logic        last;
  } result_t;

  // status from the delay unit back to the sequencer
  typedef struct packed {
    logic        done;
    logic        emit;
    logic [31:0] ticks;
  } dly_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_F));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = is_dec(c) ? (c - CH_ZERO) : (c - HEX_ALPHA_OFS);
    return d[3:0];
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

[design/rwstp_if.sv]
// Valid/ready channel interfaces for text bytes in and results out.
`timescale 1ns / 1ps

interface rwstp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface rwstp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] reg_address;
  logic [7:0]  reg_value;
  logic [31:0] delay_ticks;
  logic        last_of_run;

  modport source (output valid, output result_kind, output reg_address, output reg_value,
                  output delay_ticks, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input reg_address, input reg_value,
                  input delay_ticks, input last_of_run, output ready);
endinterface

[design/rwstp_delay_unit.sv]
// Iterative delay calculator: two shift-add multiplies and a restoring divide on one adder.
`timescale 1ns / 1ps

module rwstp_delay_unit #(
  parameter int unsigned ACCUM_WIDTH = rwstp_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ACCUM_WIDTH-1:0] int_part,
  input  logic [ACCUM_WIDTH-1:0] frac_part,
  input  logic [ACCUM_WIDTH-1:0] frac_scale,
  input  logic [31:0]            chip_rate,
  output rwstp_pkg::dly_res_t    res
);

  localparam int unsigned W  = ACCUM_WIDTH;
  localparam int unsigned CW = $clog2(W);

  typedef logic [W-1:0] acc_t;

  typedef enum logic [2:0] {
    U_IDLE, U_MUL1, U_ADD1, U_MUL2, U_ADD2, U_DIV, U_DONE
  } ust_t;

  ust_t          ust_r, ust_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  acc_t          int_r, int_nxt;
  acc_t          frac_r, frac_nxt;
  acc_t          scale_r, scale_nxt;
  acc_t          acc_r, acc_nxt;
  acc_t          div_r, div_nxt;
  acc_t          rem_r, rem_nxt;
  acc_t          q_r, q_nxt;
  logic          emit_r, emit_nxt;

  acc_t          rate_w;
  acc_t          addend;
  logic [W:0]    opa, opb;
  logic          sub;
  logic [W+1:0]  sum;
  logic          ge;

  assign rate_w = acc_t'(chip_rate);

  // shared adder / subtractor
  always_comb begin
    opa    = '0;
    opb    = '0;
    sub    = 1'b0;
    addend = '0;
    case (ust_r)
      U_MUL1: begin
        addend = scale_r[cnt_r] ? int_r : acc_t'(0);
        opa    = {1'b0, acc_r << 1};
        opb    = {1'b0, addend};
      end
      U_MUL2: begin
        addend = scale_r[cnt_r] ? rate_w : acc_t'(0);
        opa    = {1'b0, acc_r << 1};
        opb    = {1'b0, addend};
      end
      U_ADD1: begin
        opa = {1'b0, acc_r};
        opb = {1'b0, frac_r};
      end
      U_ADD2: begin
        opa = {1'b0, acc_r};
        opb = {1'b0, div_r >> 1};
      end
      U_DIV: begin
        opa = {rem_r, q_r[W-1]};
        opb = {1'b0, div_r};
        sub = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
    sum = {1'b0, opa} + ({1'b0, opb} ^ {(W+2){sub}}) + {{(W+1){1'b0}}, sub};
    ge  = ~sum[W+1];
  end

  always_comb begin
    ust_nxt   = ust_r;
    cnt_nxt   = cnt_r;
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    scale_nxt = scale_r;
    acc_nxt   = acc_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    emit_nxt  = emit_r;
    case (ust_r)
      U_IDLE: begin
        if (start) begin
          int_nxt   = int_part;
          frac_nxt  = frac_part;
          scale_nxt = frac_scale;
          acc_nxt   = '0;
          cnt_nxt   = CW'(W - 1);
          ust_nxt   = U_MUL1;
        end
      end
      U_MUL1: begin
        acc_nxt = sum[W-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) ust_nxt = U_ADD1;
      end
      U_ADD1: begin
        div_nxt  = sum[W-1:0];
        emit_nxt = (sum[W-1:0] != '0);
        acc_nxt  = '0;
        cnt_nxt  = CW'(W - 1);
        // zero divisor: nothing to compute
        ust_nxt  = (sum[W-1:0] != '0) ? U_MUL2 : U_DONE;
      end
      U_MUL2: begin
        acc_nxt = sum[W-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) ust_nxt = U_ADD2;
      end
      U_ADD2: begin
        q_nxt   = sum[W-1:0];
        rem_nxt = '0;
        cnt_nxt = CW'(W - 1);
        ust_nxt = U_DIV;
      end
      U_DIV: begin
        rem_nxt = ge ? sum[W-1:0] : opa[W-1:0];
        q_nxt   = {q_r[W-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) ust_nxt = U_DONE;
      end
      U_DONE: begin
        ust_nxt = U_IDLE;
      end
      default: begin
        ust_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      cnt_r  <= '0;
      emit_r <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      cnt_r  <= cnt_nxt;
      emit_r <= emit_nxt;
    end
    int_r   <= int_nxt;
    frac_r  <= frac_nxt;
    scale_r <= scale_nxt;
    acc_r   <= acc_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
  end

  assign res.done  = (ust_r == U_DONE);
  assign res.emit  = emit_r && (q_r != '0);
  assign res.ticks = 32'(q_r);

endmodule

[design/register_write_score_text_parser.sv]
// Top level: score text parser with byte-wise line decoding and a result queue.
// Bytes are taken one per cycle while the sequencer is idle and at most one result waits in
// the 3-entry queue; a write or end marker shows in the cycle after its byte, an end behind
// another result in the cycle after that one. A rate line stalls the input while the delay
// unit runs on its shared adder; a zero divisor skips its second multiply and the divide.
// Synchronous active-low reset: parser to line start, accumulators cleared, rate 49716.
`timescale 1ns / 1ps

module register_write_score_text_parser #(
  parameter int unsigned ACCUM_WIDTH = rwstp_pkg::ACCUM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rwstp_in_if.sink          in_if,
  rwstp_out_if.source       out_if,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  localparam int unsigned W     = ACCUM_WIDTH;
  localparam int unsigned QDEP  = 3;
  localparam int unsigned QIW   = $clog2(QDEP);

  typedef logic [W-1:0] acc_t;

  typedef enum logic [3:0] {
    M_START, M_SKIP, M_SC_SEEK, M_SC_NUM, M_R_INT, M_R_FRAC, M_W_ADDR, M_W_SEEK, M_W_VAL
  } mode_t;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_END} seq_t;

  mode_t               mode_r, mode_nxt;
  seq_t                st_r, st_nxt;
  logic                pend_end_r, pend_end_nxt;
  logic [31:0]         rate_r, rate_nxt;
  logic [7:0]          high_r, high_nxt;
  logic [7:0]          low_r, low_nxt;
  logic [7:0]          val_r, val_nxt;
  acc_t                int_r, int_nxt;
  acc_t                frac_r, frac_nxt;
  acc_t                scale_r, scale_nxt;

  rwstp_pkg::result_t  q_r [QDEP];
  logic [QIW-1:0]      head_r, head_nxt;
  logic [QIW-1:0]      tail_r, tail_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  // post-byte values, before the end-of-text clear
  mode_t               p_mode;
  logic [7:0]          p_high, p_low, p_val;
  acc_t                p_int, p_frac, p_scale;

  logic [7:0]          c;
  logic                fin;
  logic                in_fire;
  logic                out_fire;
  logic                emit_w;
  logic                start_d;
  logic                push;
  rwstp_pkg::result_t  push_data;
  rwstp_pkg::dly_res_t dres;
  logic [3:0]          dec_d;
  logic [3:0]          hex_d;

  assign c        = in_if.text_byte;
  assign fin      = in_if.final_byte;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign dec_d    = 4'(c - rwstp_pkg::CH_ZERO);
  assign hex_d    = rwstp_pkg::hex_val(c);

  assign in_if.ready = (st_r == S_IDLE) && (cnt_r <= 2'd1);

  // line parser
  always_comb begin
    p_mode  = mode_r;
    p_high  = high_r;
    p_low   = low_r;
    p_val   = val_r;
    p_int   = int_r;
    p_frac  = frac_r;
    p_scale = scale_r;
    emit_w  = 1'b0;
    start_d = 1'b0;

    if (mode_r == M_START && !rwstp_pkg::is_ws(c)) begin
      p_low   = '0;
      p_val   = '0;
      p_int   = '0;
      p_frac  = '0;
      p_scale = acc_t'(1);
      if (c == rwstp_pkg::CH_I) begin
        p_mode = M_SKIP;
      end else if (c == rwstp_pkg::CH_S) begin
        p_high = '0;
        p_mode = M_SC_SEEK;
      end else if (c == rwstp_pkg::CH_R) begin
        p_mode = M_R_INT;
      end else if (rwstp_pkg::is_hex(c)) begin
        p_low  = {4'd0, hex_d};
        p_mode = M_W_ADDR;
      end else begin
        p_mode = M_W_SEEK;
      end
    end else begin
      case (mode_r)
        M_SKIP: begin
          if (rwstp_pkg::is_eol(c)) p_mode = M_START;
        end
        M_SC_SEEK: begin
          if (rwstp_pkg::is_dec(c)) begin
            p_high = {4'd0, dec_d};
            p_mode = M_SC_NUM;
          end
        end
        M_SC_NUM: begin
          if (rwstp_pkg::is_dec(c)) begin
            p_high = (high_r << 3) + (high_r << 1) + {4'd0, dec_d};
          end else begin
            p_mode = rwstp_pkg::is_eol(c) ? M_START : M_SKIP;
          end
        end
        M_R_INT: begin
          if (rwstp_pkg::is_dec(c)) begin
            p_int = (int_r << 3) + (int_r << 1) + acc_t'(dec_d);
          end else begin
            // any non-digit byte ends the integer digits
            p_mode = M_R_FRAC;
          end
        end
        M_R_FRAC: begin
          if (rwstp_pkg::is_dec(c)) begin
            p_frac  = (frac_r << 3) + (frac_r << 1) + acc_t'(dec_d);
            p_scale = (scale_r << 3) + (scale_r << 1);
          end else begin
            start_d = 1'b1;
            p_mode  = rwstp_pkg::is_eol(c) ? M_START : M_SKIP;
          end
        end
        M_W_ADDR: begin
          if (rwstp_pkg::is_hex(c)) p_low = {low_r[3:0], hex_d};
          else                      p_mode = M_W_SEEK;
        end
        M_W_SEEK: begin
          if (rwstp_pkg::is_hex(c)) begin
            p_val  = {4'd0, hex_d};
            p_mode = M_W_VAL;
          end
        end
        M_W_VAL: begin
          if (rwstp_pkg::is_hex(c)) begin
            p_val = {val_r[3:0], hex_d};
          end else begin
            emit_w = 1'b1;
            p_mode = rwstp_pkg::is_eol(c) ? M_START : M_SKIP;
          end
        end
        default: begin
          p_mode = mode_r;
        end
      endcase
    end

    // end of text flushes an open rate or write line
    if (fin) begin
      if (p_mode == M_R_INT || p_mode == M_R_FRAC) start_d = 1'b1;
      if (p_mode == M_W_ADDR || p_mode == M_W_SEEK || p_mode == M_W_VAL) emit_w = 1'b1;
    end
  end

  // sequencer, queue and register next values
  always_comb begin
    mode_nxt     = mode_r;
    high_nxt     = high_r;
    low_nxt      = low_r;
    val_nxt      = val_r;
    int_nxt      = int_r;
    frac_nxt     = frac_r;
    scale_nxt    = scale_r;
    rate_nxt     = cfg_we ? cfg_wdata : rate_r;
    st_nxt       = st_r;
    pend_end_nxt = pend_end_r;
    push         = 1'b0;
    push_data    = '0;

    if (in_fire) begin
      high_nxt = p_high;
      if (fin) begin
        mode_nxt  = M_START;
        low_nxt   = '0;
        val_nxt   = '0;
        int_nxt   = '0;
        frac_nxt  = '0;
        scale_nxt = acc_t'(1);
      end else begin
        mode_nxt  = p_mode;
        low_nxt   = p_low;
        val_nxt   = p_val;
        int_nxt   = p_int;
        frac_nxt  = p_frac;
        scale_nxt = p_scale;
      end
    end

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          if (start_d) begin
            st_nxt       = S_CALC;
            pend_end_nxt = fin;
          end else if (emit_w) begin
            push              = 1'b1;
            push_data.kind    = rwstp_pkg::KIND_WRITE;
            push_data.address = {p_high, p_low};
            push_data.value   = p_val;
            push_data.last    = !fin;
            if (fin) st_nxt = S_END;
          end else if (fin) begin
            push           = 1'b1;
            push_data.kind = rwstp_pkg::KIND_END;
            push_data.last = 1'b1;
          end
        end
      end
      S_CALC: begin
        if (dres.done) begin
          if (dres.emit) begin
            push            = 1'b1;
            push_data.kind  = rwstp_pkg::KIND_DELAY;
            push_data.ticks = dres.ticks;
            push_data.last  = !pend_end_r;
          end
          st_nxt = pend_end_r ? S_END : S_IDLE;
        end
      end
      S_END: begin
        push           = 1'b1;
        push_data.kind = rwstp_pkg::KIND_END;
        push_data.last = 1'b1;
        st_nxt         = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    tail_nxt = tail_r;
    head_nxt = head_r;
    if (push)     tail_nxt = (tail_r == QIW'(QDEP - 1)) ? '0 : tail_r + 1'b1;
    if (out_fire) head_nxt = (head_r == QIW'(QDEP - 1)) ? '0 : head_r + 1'b1;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, out_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_START;
      st_r       <= S_IDLE;
      pend_end_r <= 1'b0;
      rate_r     <= rwstp_pkg::CHIP_RATE_RESET;
      high_r     <= '0;
      low_r      <= '0;
      val_r      <= '0;
      int_r      <= '0;
      frac_r     <= '0;
      scale_r    <= acc_t'(1);
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
    end else begin
      mode_r     <= mode_nxt;
      st_r       <= st_nxt;
      pend_end_r <= pend_end_nxt;
      rate_r     <= rate_nxt;
      high_r     <= high_nxt;
      low_r      <= low_nxt;
      val_r      <= val_nxt;
      int_r      <= int_nxt;
      frac_r     <= frac_nxt;
      scale_r    <= scale_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      if (push) q_r[tail_r] <= push_data;
    end
  end

  rwstp_delay_unit #(
    .ACCUM_WIDTH (ACCUM_WIDTH)
  ) u_delay (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire && start_d),
    .int_part   (p_int),
    .frac_part  (p_frac),
    .frac_scale (p_scale),
    .chip_rate  (rate_r),
    .res        (dres)
  );

  assign out_if.valid       = (cnt_r != 2'd0);
  assign out_if.result_kind = q_r[head_r].kind;
  assign out_if.reg_address = q_r[head_r].address;
  assign out_if.reg_value   = q_r[head_r].value;
  assign out_if.delay_ticks = q_r[head_r].ticks;
  assign out_if.last_of_run = q_r[head_r].last;

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_fire) |-> (cnt_r != 2'd3))
    else $error("result queue overflow");

  a_done_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    dres.done |-> (st_r == S_CALC))
    else $error("delay unit finished outside of a calculation");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.result_kind == rwstp_pkg::KIND_END) |-> out_if.last_of_run)
    else $error("end marker not flagged as last item");

  a_calc_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && start_d) |=> (!in_if.ready && st_r == S_CALC))
    else $error("input not stalled during delay calculation");

endmodule

[tb/sv/register_write_score_text_parser_tb.sv]
// Self-checking testbench for the score text parser: random score text, predicted results.
`timescale 1ns / 1ps

module register_write_score_text_parser_tb;

  localparam int DRAIN_CYCLES = 3 * rwstp_pkg::ACCUM_WIDTH_DEF + 32;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_BYTES  = 200;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_UP_A = 8'h41;

  typedef enum logic [3:0] {
    PM_START, PM_SKIP, PM_SC_SEEK, PM_SC_NUM, PM_R_INT, PM_R_FRAC,
    PM_W_ADDR, PM_W_SEEK, PM_W_VAL
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  rwstp_in_if  text_ch ();
  rwstp_out_if result_ch ();

  register_write_score_text_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (text_ch),
    .out_if    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // parser state as predicted
  parse_mode_t mode      = PM_START;
  logic [7:0]  hi_addr   = 8'h00;
  logic [7:0]  lo_acc    = 8'h00;
  logic [7:0]  val_acc   = 8'h00;
  logic [31:0] int_acc   = 32'd0;
  logic [31:0] frac_acc  = 32'd0;
  logic [31:0] frac_scale = 32'd1;
  logic [31:0] rate_model = rwstp_pkg::CHIP_RATE_RESET;

  text_item_t          score_text[$];
  rwstp_pkg::result_t  pending_results[$];
  rwstp_pkg::result_t  step_out[$];
  logic [7:0]          line_buf[$];

  int errors = 0;
  int quiet_cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  int in_odds = 6;
  int out_odds = 6;

  function automatic bit blank_ch(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == rwstp_pkg::CH_SPACE;
  endfunction

  function automatic bit dec_ch(input logic [7:0] c);
    return c >= rwstp_pkg::CH_ZERO && c <= rwstp_pkg::CH_NINE;
  endfunction

  function automatic bit hex_ch(input logic [7:0] c);
    return dec_ch(c) || (c >= rwstp_pkg::CH_LOW_A && c <= rwstp_pkg::CH_LOW_F);
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    return 4'(dec_ch(c) ? c - rwstp_pkg::CH_ZERO : c - rwstp_pkg::HEX_ALPHA_OFS);
  endfunction

  function automatic parse_mode_t after_number(input logic [7:0] c);
    return (c == rwstp_pkg::CH_LF || c == rwstp_pkg::CH_CR) ? PM_START : PM_SKIP;
  endfunction

  task automatic add_result(input logic [1:0] k, input logic [15:0] a, input logic [7:0] v,
                            input logic [31:0] t);
    rwstp_pkg::result_t r;
    r = '{kind: k, address: a, value: v, ticks: t, last: 1'b0};
    step_out.push_back(r);
  endtask

  task automatic add_write();
    add_result(rwstp_pkg::KIND_WRITE, {hi_addr, lo_acc}, val_acc, 32'd0);
  endtask

  // round(rate * scale / divisor), all 32-bit wrapping
  task automatic add_delay();
    logic [31:0] divisor, numer;
    divisor = int_acc * frac_scale + frac_acc;
    if (divisor != 32'd0) begin
      numer = rate_model * frac_scale + (divisor >> 1);
      if (numer / divisor != 32'd0)
        add_result(rwstp_pkg::KIND_DELAY, 16'h0000, 8'h00, numer / divisor);
    end
  endtask

  task automatic clear_accums();
    lo_acc = 8'h00;
    val_acc = 8'h00;
    int_acc = 32'd0;
    frac_acc = 32'd0;
    frac_scale = 32'd1;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic fin);
    step_out.delete();
    if (mode == PM_START && !blank_ch(c)) begin
      clear_accums();
      if (c == rwstp_pkg::CH_I) begin
        mode = PM_SKIP;
      end else if (c == rwstp_pkg::CH_S) begin
        hi_addr = 8'h00;
        mode = PM_SC_SEEK;
      end else if (c == rwstp_pkg::CH_R) begin
        mode = PM_R_INT;
      end else if (hex_ch(c)) begin
        lo_acc = {4'h0, nibble(c)};
        mode = PM_W_ADDR;
      end else begin
        mode = PM_W_SEEK;
      end
    end else begin
      case (mode)
        PM_SKIP: if (c == rwstp_pkg::CH_LF || c == rwstp_pkg::CH_CR) mode = PM_START;
        PM_SC_SEEK: begin
          if (dec_ch(c)) begin
            hi_addr = c - rwstp_pkg::CH_ZERO;
            mode = PM_SC_NUM;
          end
        end
        PM_SC_NUM: begin
          if (dec_ch(c)) hi_addr = hi_addr * 8'd10 + (c - rwstp_pkg::CH_ZERO);
          else mode = after_number(c);
        end
        // any non-digit ends the integer part, line ends included
        PM_R_INT: begin
          if (dec_ch(c)) int_acc = int_acc * 32'd10 + 32'(c - rwstp_pkg::CH_ZERO);
          else mode = PM_R_FRAC;
        end
        PM_R_FRAC: begin
          if (dec_ch(c)) begin
            frac_acc = frac_acc * 32'd10 + 32'(c - rwstp_pkg::CH_ZERO);
            frac_scale = frac_scale * 32'd10;
          end else begin
            add_delay();
            mode = after_number(c);
          end
        end
        PM_W_ADDR: begin
          if (hex_ch(c)) lo_acc = {lo_acc[3:0], nibble(c)};
          else mode = PM_W_SEEK;
        end
        PM_W_SEEK: begin
          if (hex_ch(c)) begin
            val_acc = {4'h0, nibble(c)};
            mode = PM_W_VAL;
          end
        end
        PM_W_VAL: begin
          if (hex_ch(c)) begin
            val_acc = {val_acc[3:0], nibble(c)};
          end else begin
            add_write();
            mode = after_number(c);
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      if (mode == PM_R_INT || mode == PM_R_FRAC) add_delay();
      else if (mode == PM_W_ADDR || mode == PM_W_SEEK || mode == PM_W_VAL) add_write();
      add_result(rwstp_pkg::KIND_END, 16'h0000, 8'h00, 32'd0);
      mode = PM_START;
      clear_accums();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
  endtask

  // ---- text generation ----
  function automatic logic [7:0] dec_rand();
    return 8'(rwstp_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] hex_rand();
    int d;
    d = $urandom_range(0, 15);
    // uppercase is not a hex digit here
    if ($urandom_range(0, 15) == 0) return 8'(CH_UP_A + $urandom_range(0, 5));
    return (d < 10) ? 8'(rwstp_pkg::CH_ZERO + d) : 8'(rwstp_pkg::CH_LOW_A + (d - 10));
  endfunction

  function automatic logic [7:0] blank_rand();
    return ($urandom_range(0, 1) == 0) ? rwstp_pkg::CH_SPACE : 8'(9 + $urandom_range(0, 4));
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  task automatic add_ch(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // moves the line into the text; may cut it short and end the text there
  task automatic flush_line(input bit may_cut, input bit end_text);
    int n;
    n = line_buf.size();
    if (may_cut && $urandom_range(0, 15) == 0) begin
      n = $urandom_range(1, n);
      end_text = 1'b1;
    end
    for (int i = 0; i < n; i++)
      score_text.push_back('{ch: line_buf[i], fin: end_text && (i == n - 1)});
    line_buf.delete();
  endtask

  task automatic random_line();
    int pick, k;
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) add_ch(blank_rand());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      repeat ($urandom_range(1, 3)) add_ch(hex_rand());
      case ($urandom_range(0, 3))
        0: add_text(" <- ");
        1: add_text("<-");
        2: add_text(" ");
        default: add_text("\t<-\t");
      endcase
      // no data digits: the search runs into the next line
      k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      repeat (k) add_ch(hex_rand());
    end else if (pick < 60) begin
      add_ch(rwstp_pkg::CH_R);
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 3);
      repeat (k) add_ch(dec_rand());
      add_ch(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_DOT);
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 4);
      repeat (k) add_ch(dec_rand());
    end else if (pick < 70) begin
      add_ch(rwstp_pkg::CH_S);
      if ($urandom_range(0, 1) == 0) add_text("etchip ");
      k = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      repeat (k) add_ch(dec_rand());
    end else if (pick < 78) begin
      add_ch(rwstp_pkg::CH_I);
      repeat ($urandom_range(0, 6)) add_ch(8'($urandom_range(32, 126)));
    end else begin
      repeat ($urandom_range(1, 8)) add_ch(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) add_text(" ; x");
    case ($urandom_range(0, 3))
      0, 1: add_ch(rwstp_pkg::CH_LF);
      2: add_ch(rwstp_pkg::CH_CR);
      default: begin
        add_ch(rwstp_pkg::CH_CR);
        add_ch(rwstp_pkg::CH_LF);
      end
    endcase
    flush_line(1'b1, 1'b0);
  endtask

  task automatic fill_text(input int n);
    while (score_text.size() < n) random_line();
    score_text[score_text.size() - 1].fin = 1'b1;
  endtask

  // idle: all text taken, all results seen, and the delay unit given time to finish
  task automatic settle();
    while (score_text.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chip_rate(input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    rate_model = v;
  endtask

  // ---- input driver ----
  always @(negedge clk) begin
    if (!rst_n || in_gap > 0 || score_text.size() == 0) begin
      text_ch.valid <= 1'b0;
      if (in_gap > 0) in_gap--;
    end else begin
      text_ch.valid <= 1'b1;
      text_ch.text_byte <= score_text[0].ch;
      text_ch.final_byte <= score_text[0].fin;
    end
  end

  // ---- result ready ----
  always @(negedge clk) begin
    if (out_stall > 0) begin
      result_ch.ready <= 1'b0;
      out_stall--;
    end else if (out_odds != 0 && $urandom_range(1, out_odds) == 1) begin
      result_ch.ready <= 1'b0;
      out_stall = $urandom_range(0, 18);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // ---- prediction and checking ----
  always @(posedge clk) begin : monitor
    rwstp_pkg::result_t got, want;
    if (rst_n) begin
      if (text_ch.valid && text_ch.ready) begin
        parse_byte(text_ch.text_byte, text_ch.final_byte);
        void'(score_text.pop_front());
        if (in_odds != 0 && $urandom_range(1, in_odds) == 1) in_gap = $urandom_range(1, 19);
      end
      if (result_ch.valid && result_ch.ready) begin
        got = '{kind: result_ch.result_kind, address: result_ch.reg_address,
                value: result_ch.reg_value, ticks: result_ch.delay_ticks,
                last: result_ch.last_of_run};
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d addr=%h value=%h ticks=%0d last=%0b",
                   $time, got.kind, got.address, got.value, got.ticks, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d addr=%h value=%h ticks=%0d last=%0b",
                     $time, want.kind, want.address, want.value, want.ticks, want.last);
            $display("%0t:          actual   kind=%0d addr=%h value=%h ticks=%0d last=%0b",
                     $time, got.kind, got.address, got.value, got.ticks, got.last);
          end
        end
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] rate_plan[4];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 32'd0;
    text_ch.valid = 1'b0;
    text_ch.text_byte = 8'h00;
    text_ch.final_byte = 1'b0;
    result_ch.ready = 1'b0;
    rate_plan[0] = 32'hFFFF_FFFF;
    rate_plan[1] = 32'd1;
    rate_plan[2] = $urandom_range(2, 32'hFFFF_FFFE);
    rate_plan[3] = 32'd44100;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // setchip wrap, write, rate line, skip line with CR, zero divisor,
    // extreme bytes opening a write, then the text ends on a pending write
    add_text("s300\nff-a0\nr1.5\ni");
    add_ch(rwstp_pkg::CH_CR);
    add_text("r0.0\n");
    add_ch(8'hFF);
    add_ch(8'h00);
    add_text("7");
    flush_line(1'b0, 1'b1);
    fill_text(PHASE_BYTES);
    settle();

    foreach (rate_plan[p]) begin
      write_chip_rate(rate_plan[p]);
      if (p == 3) begin
        in_odds = 0;
        out_odds = 0;
      end else begin
        in_odds = pick_odds();
        out_odds = pick_odds();
      end
      fill_text(PHASE_BYTES);
      settle();
    end

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
